// ----- design/mmnb_pkg.sv -----
`timescale 1ns / 1ps
// Package for the min/max contrast stretch block: op codes, word types and constants.
// It depends on nothing; every module of the block imports it.
package mmnb_pkg;

   localparam int MaxRows = 4096;
   localparam int MaxCols = 4096;
   localparam int QuotBits = 8;

   localparam logic signed [31:0] MinReset = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MaxReset = 32'sh8000_0000;
   localparam logic [7:0] FullScale = 8'd255;

   typedef enum logic [1:0] {
      OP_RESTART = 2'd0,
      OP_SCAN    = 2'd1,
      OP_CONVERT = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] pixel_value;
      logic [11:0]        pixel_row;
      logic [11:0]        pixel_col;
   } req_word_type;

   typedef struct packed {
      logic [7:0]         scaled_pixel;
      logic signed [31:0] min_value;
      logic signed [31:0] max_value;
      logic [11:0]        min_row;
      logic [11:0]        min_col;
      logic [11:0]        max_row;
      logic [11:0]        max_col;
   } rsp_word_type;

   typedef struct packed {
      logic signed [31:0] min_value;
      logic signed [31:0] max_value;
      logic [11:0]        min_row;
      logic [11:0]        min_col;
      logic [11:0]        max_row;
      logic [11:0]        max_col;
   } stats_type;

   localparam stats_type StatsReset = '{
      min_value: MinReset,
      max_value: MaxReset,
      min_row:   12'd0,
      min_col:   12'd0,
      max_row:   12'd0,
      max_col:   12'd0
   };

   typedef struct packed {
      logic          valid;
      logic          fixed;
      logic [7:0]    fixed_pixel;
      logic [31:0]   numer;
      logic [31:0]   divisor;
      stats_type     stats;
   } pre_word_type;

   typedef struct packed {
      logic                valid;
      logic                fixed;
      logic [7:0]          fixed_pixel;
      logic [31:0]         partial;
      logic [QuotBits-1:0] low_bits;
      logic [31:0]         divisor;
      logic [QuotBits-1:0] quotient;
      stats_type           stats;
   } cell_word_type;

endpackage

// ----- design/mmnb_stats.sv -----
`timescale 1ns / 1ps
// Running minimum and maximum with the positions where each was first seen.
// Depends on mmnb_pkg.
module mmnb_stats (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  mmnb_pkg::req_word_type    req_word,
   output mmnb_pkg::stats_type       stats_cur,
   output mmnb_pkg::stats_type       stats_nxt
);
   import mmnb_pkg::*;

   stats_type stats_ff;
   stats_type stats_in;
   logic      in_range;

   assign in_range = ({20'd0, req_word.pixel_row} < 32'(MaxRows)) &&
                     ({20'd0, req_word.pixel_col} < 32'(MaxCols));

   always_comb begin
      stats_in = stats_ff;
      case (op_type'(req_word.op))
         OP_RESTART: begin
            stats_in = StatsReset;
         end
         OP_SCAN: begin
            if (in_range) begin
               if (req_word.pixel_value > stats_ff.max_value) begin
                  stats_in.max_value = req_word.pixel_value;
                  stats_in.max_row   = req_word.pixel_row;
                  stats_in.max_col   = req_word.pixel_col;
               end
               if (req_word.pixel_value < stats_ff.min_value) begin
                  stats_in.min_value = req_word.pixel_value;
                  stats_in.min_row   = req_word.pixel_row;
                  stats_in.min_col   = req_word.pixel_col;
               end
            end
         end
         default: begin
            stats_in = stats_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff <= StatsReset;
      end else if (accept) begin
         stats_ff <= stats_in;
      end
   end

   assign stats_cur = stats_ff;
   assign stats_nxt = stats_in;

endmodule

// ----- design/mmnb_cell.sv -----
`timescale 1ns / 1ps
// One cell of the restoring divider chain: it settles one quotient bit per word.
// Depends on mmnb_pkg.
module mmnb_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  mmnb_pkg::cell_word_type  cell_in_word,
   output mmnb_pkg::cell_word_type  cell_out_word
);
   import mmnb_pkg::*;

   cell_word_type word_ff;
   cell_word_type word_in;
   logic [32:0]   trial;
   logic [32:0]   wide_div;
   logic          take;

   always_comb begin
      trial    = {cell_in_word.partial, cell_in_word.low_bits[QuotBits-1]};
      wide_div = {1'b0, cell_in_word.divisor};
      take     = trial >= wide_div;
      word_in  = cell_in_word;
      word_in.partial  = take ? 32'(trial - wide_div) : trial[31:0];
      word_in.low_bits = {cell_in_word.low_bits[QuotBits-2:0], 1'b0};
      word_in.quotient = {cell_in_word.quotient[QuotBits-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff <= word_in;
      end
   end

   assign cell_out_word = word_ff;

endmodule

// ----- design/int_min_max_normalize_to_byte.sv -----
`timescale 1ns / 1ps
// Top level of the min/max contrast stretch; depends on mmnb_pkg, mmnb_stats and mmnb_cell.
// The block takes one word per cycle unless a stalled result holds it, and passes each
// word through one entry stage, one stage that forms (v - min) * 255, and a chain of eight
// divider cells that each produce one quotient bit. A stall on a valid result freezes the
// whole chain, and the input is stalled for as long as the result waits. Every result
// carries the statistics as they stand after its own word.
module int_min_max_normalize_to_byte (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mmnb_pkg::req_word_type  req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mmnb_pkg::rsp_word_type  rsp_word
);
   import mmnb_pkg::*;

   logic               advance;
   logic               accept;
   stats_type          stats_cur;
   stats_type          stats_nxt;
   pre_word_type       pre_ff;
   pre_word_type       pre_in;
   cell_word_type      head_ff;
   cell_word_type      head_in;
   cell_word_type      chain [0:QuotBits];
   logic signed [32:0] lo_ext;
   logic signed [32:0] hi_ext;
   logic signed [32:0] x_ext;
   logic signed [32:0] span;
   logic signed [32:0] offset;
   logic               flat;
   logic               below;
   logic               above;
   logic [39:0]        product;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   mmnb_stats u_stats (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_word  (req_word),
      .stats_cur (stats_cur),
      .stats_nxt (stats_nxt)
   );

   always_comb begin
      lo_ext = {stats_cur.min_value[31], stats_cur.min_value};
      hi_ext = {stats_cur.max_value[31], stats_cur.max_value};
      x_ext  = {req_word.pixel_value[31], req_word.pixel_value};
      span   = hi_ext - lo_ext;
      offset = x_ext - lo_ext;
      flat   = hi_ext <= lo_ext;
      below  = x_ext <= lo_ext;
      above  = x_ext >= hi_ext;
      pre_in.valid   = req_valid;
      pre_in.numer   = offset[31:0];
      pre_in.divisor = span[31:0];
      pre_in.stats   = stats_nxt;
      if (op_type'(req_word.op) == OP_CONVERT) begin
         pre_in.fixed       = flat || below || above;
         pre_in.fixed_pixel = (below && !flat) ? 8'd0 : FullScale;
      end else begin
         pre_in.fixed       = 1'b1;
         pre_in.fixed_pixel = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff.valid <= 1'b0;
      end else if (advance) begin
         pre_ff <= pre_in;
      end
   end

   always_comb begin
      product = {pre_ff.numer, 8'd0} - {8'd0, pre_ff.numer};
      head_in.valid       = pre_ff.valid;
      head_in.fixed       = pre_ff.fixed;
      head_in.fixed_pixel = pre_ff.fixed_pixel;
      head_in.partial     = product[39:QuotBits];
      head_in.low_bits    = product[QuotBits-1:0];
      head_in.divisor     = pre_ff.divisor;
      head_in.quotient    = '0;
      head_in.stats       = pre_ff.stats;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (advance) begin
         head_ff <= head_in;
      end
   end

   assign chain[0] = head_ff;

   for (genvar gi = 0; gi < QuotBits; gi++) begin : g_cell
      mmnb_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .cell_in_word  (chain[gi]),
         .cell_out_word (chain[gi+1])
      );
   end

   always_comb begin
      rsp_valid             = chain[QuotBits].valid;
      rsp_word.scaled_pixel = chain[QuotBits].fixed ? chain[QuotBits].fixed_pixel
                                                    : chain[QuotBits].quotient;
      rsp_word.min_value    = chain[QuotBits].stats.min_value;
      rsp_word.max_value    = chain[QuotBits].stats.max_value;
      rsp_word.min_row      = chain[QuotBits].stats.min_row;
      rsp_word.min_col      = chain[QuotBits].stats.min_col;
      rsp_word.max_row      = chain[QuotBits].stats.max_row;
      rsp_word.max_col      = chain[QuotBits].stats.max_col;
   end

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_empty_stats: assert property (@(posedge clock) disable iff (reset)
      (stats_cur.max_value < stats_cur.min_value) |->
      (stats_cur.min_value == MinReset && stats_cur.max_value == MaxReset))
      else $error("maximum below minimum outside the empty state");

   a_quotient_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !chain[QuotBits].fixed) |-> (chain[QuotBits].quotient != FullScale))
      else $error("divided result reached full scale");

endmodule

// ----- bench/stretch_checker.sv -----
`timescale 1ns / 1ps
// Checker for the min/max contrast stretch: watches both channels and predicts every result.
// It depends on mmnb_pkg and keeps its own copy of the running statistics.
module stretch_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  mmnb_pkg::req_word_type req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  mmnb_pkg::rsp_word_type rsp_word,
   output int                     fail_count,
   output int                     pending,
   output int                     checked
);
   import mmnb_pkg::*;

   stats_type    stats;
   rsp_word_type expected_words[$];

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
   end

   function automatic logic [7:0] stretch_to_byte(logic signed [31:0] v,
                                                   logic signed [31:0] lo,
                                                   logic signed [31:0] hi);
      longint x;
      longint l;
      longint h;
      longint q;
      x = longint'(v);
      l = longint'(lo);
      h = longint'(hi);
      if (h <= l) return FullScale;
      if (x <= l) return 8'd0;
      if (x >= h) return FullScale;
      q = ((x - l) * 255) / (h - l);
      return q[7:0];
   endfunction

   task automatic report_field(string name, longint want, longint got);
      if (want != got) begin
         $error("Field %s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type next;
      if (reset) begin
         stats = StatsReset;
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("Result word arrived with no expected word waiting");
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               report_field("scaled_pixel", longint'(want.scaled_pixel),
                            longint'(rsp_word.scaled_pixel));
               report_field("min_value", longint'(want.min_value),
                            longint'(rsp_word.min_value));
               report_field("max_value", longint'(want.max_value),
                            longint'(rsp_word.max_value));
               report_field("min_row", longint'(want.min_row), longint'(rsp_word.min_row));
               report_field("min_col", longint'(want.min_col), longint'(rsp_word.min_col));
               report_field("max_row", longint'(want.max_row), longint'(rsp_word.max_row));
               report_field("max_col", longint'(want.max_col), longint'(rsp_word.max_col));
               checked++;
            end
         end
         if (req_valid && !req_stall) begin
            next.scaled_pixel = 8'd0;
            case (req_word.op)
               OP_RESTART: stats = StatsReset;
               OP_SCAN: begin
                  if (req_word.pixel_row < MaxRows && req_word.pixel_col < MaxCols) begin
                     if (req_word.pixel_value > stats.max_value) begin
                        stats.max_value = req_word.pixel_value;
                        stats.max_row   = req_word.pixel_row;
                        stats.max_col   = req_word.pixel_col;
                     end
                     if (req_word.pixel_value < stats.min_value) begin
                        stats.min_value = req_word.pixel_value;
                        stats.min_row   = req_word.pixel_row;
                        stats.min_col   = req_word.pixel_col;
                     end
                  end
               end
               OP_CONVERT: next.scaled_pixel = stretch_to_byte(req_word.pixel_value,
                                                               stats.min_value,
                                                               stats.max_value);
               default: ;
            endcase
            next.min_value = stats.min_value;
            next.max_value = stats.max_value;
            next.min_row   = stats.min_row;
            next.min_col   = stats.min_col;
            next.max_row   = stats.max_row;
            next.max_col   = stats.max_col;
            expected_words.push_back(next);
         end
      end
      pending <= expected_words.size();
   end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the contrast stretch testbench: clock, reset, stimulus, stall patterns and verdict.
// It depends on mmnb_pkg, int_min_max_normalize_to_byte and stretch_checker.
module tb_top;
   import mmnb_pkg::*;

   localparam logic [1:0] OpUnused = 2'd3;
   localparam int RandomItems = 410;
   localparam int IdleLimit = 2000;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int fail_count;
   int pending;
   int checked;
   int idle_cycles = 0;
   int burst_left = 0;
   int op_counts[4] = '{0, 0, 0, 0};
   int random_sent = 0;
   int stall_mode = 0;
   int stall_timer = 0;

   int_min_max_normalize_to_byte i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   stretch_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  <= $urandom_range(0, 2);
         stall_timer <= $urandom_range(16, 96);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 30);
         default: rsp_stall <= ($urandom_range(0, 99) < 80);
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("Timeout after %0d cycles without a handshake", IdleLimit);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic push_word(logic [1:0] op, logic [31:0] value, logic [11:0] row,
                            logic [11:0] col);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_word.op          <= op;
      req_word.pixel_value <= value;
      req_word.pixel_row   <= row;
      req_word.pixel_col   <= col;
      op_counts[op]++;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   function automatic logic [31:0] pick_pixel(logic [31:0] base, logic [31:0] spread);
      case ($urandom_range(0, 19))
         0: return MaxReset;
         1: return MinReset;
         2, 3: return $urandom();
         4: return base - $urandom_range(1, 4);
         5: return base + spread + $urandom_range(1, 4);
         default: return base + $urandom_range(0, spread);
      endcase
   endfunction

   initial begin
      logic [31:0] base;
      logic [31:0] spread;
      int          scans;
      int          converts;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      push_word(OP_CONVERT, 32'd0, 12'd0, 12'd0);
      push_word(OP_SCAN, 32'd100, 12'd1, 12'd2);
      push_word(OP_CONVERT, 32'd100, 12'd0, 12'd0);
      push_word(OP_SCAN, 32'd100, 12'd3, 12'd4);
      push_word(OP_SCAN, MinReset, 12'd4095, 12'd4095);
      push_word(OP_SCAN, MaxReset, 12'd0, 12'd0);
      push_word(OP_SCAN, MinReset, 12'd5, 12'd5);
      push_word(OP_SCAN, MaxReset, 12'd6, 12'd6);
      push_word(OP_CONVERT, MaxReset, 12'd0, 12'd0);
      push_word(OP_CONVERT, MinReset, 12'd0, 12'd0);
      push_word(OP_CONVERT, 32'd0, 12'd0, 12'd0);
      push_word(OP_CONVERT, 32'hFFFF_FFFF, 12'd0, 12'd0);
      push_word(OP_CONVERT, 32'h7FFF_FFFE, 12'd0, 12'd0);
      push_word(OP_CONVERT, 32'h8000_0001, 12'd0, 12'd0);
      push_word(OpUnused, $urandom(), 12'd4095, 12'd4095);
      push_word(OP_RESTART, 32'hFFFF_FFFF, 12'd4095, 12'd4095);
      push_word(OP_CONVERT, 32'd5, 12'd0, 12'd0);
      push_word(OP_SCAN, -32'sd5, 12'd7, 12'd9);
      push_word(OP_SCAN, 32'd10, 12'd8, 12'd10);
      push_word(OP_CONVERT, -32'sd6, 12'd0, 12'd0);
      push_word(OP_CONVERT, 32'd11, 12'd0, 12'd0);
      push_word(OP_CONVERT, 32'd3, 12'd0, 12'd0);
      push_word(OP_RESTART, 32'd0, 12'd0, 12'd0);

      while (random_sent < RandomItems) begin
         case ($urandom_range(0, 3))
            0: spread = 32'd0;
            1: spread = 32'd15;
            2: spread = 32'd4095;
            default: spread = 32'hFFFF_FFFF;
         endcase
         base = $urandom();
         if ($urandom_range(0, 9) != 0) begin
            push_word(OP_RESTART, $urandom(), 12'($urandom()), 12'($urandom()));
            random_sent++;
         end
         scans = $urandom_range(1, 30);
         repeat (scans) begin
            push_word(OP_SCAN, pick_pixel(base, spread), 12'($urandom()), 12'($urandom()));
            random_sent++;
         end
         converts = $urandom_range(1, 30);
         repeat (converts) begin
            case ($urandom_range(0, 19))
               0: push_word(OpUnused, $urandom(), 12'($urandom()), 12'($urandom()));
               1: push_word(OP_SCAN, pick_pixel(base, spread), 12'($urandom()),
                            12'($urandom()));
               default: push_word(OP_CONVERT, pick_pixel(base, spread), 12'($urandom()),
                                  12'($urandom()));
            endcase
            random_sent++;
         end
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Sent %0d words: %0d restarts, %0d scans, %0d converts, %0d unused ops.",
               op_counts[0] + op_counts[1] + op_counts[2] + op_counts[3],
               op_counts[0], op_counts[1], op_counts[2], op_counts[3]);
      $display("Checked %0d result words against the prediction.", checked);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
